// ----- rtl/tfph_pkg.sv -----
// ----------------------------------------------------------------------------
// tfph_pkg
// Shared types, constants and helpers for the tunnel frame parse/hash core.
// ----------------------------------------------------------------------------
package tfph_pkg;

  localparam int          MAX_FRAME_BYTES_DEFAULT = 16384;
  localparam logic [15:0] TUNNEL_PORT_RESET       = 16'd2152;
  localparam logic [15:0] ETHERTYPE_IPV4          = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4            = 4'd4;
  localparam logic [31:0] HASH_SEED               = 32'd5381;
  localparam logic [4:0]  TUNNEL_HDR_BASE         = 5'd8;

  // GTP flag bits that extend the tunnel header
  localparam int FLAG_ADD4_BIT = 5;  // 0x20
  localparam int FLAG_ADD2_BIT = 6;  // 0x40
  localparam int FLAG_ADD1_BIT = 7;  // 0x80

  typedef enum logic [3:0] {
    ST_OK                = 4'd0,
    ST_TOO_SHORT         = 4'd1,
    ST_NOT_IP            = 4'd2,
    ST_NOT_IPV4          = 4'd3,
    ST_HDR_INCOMPLETE    = 4'd4,
    ST_WRONG_PORT        = 4'd5,
    ST_TUNNEL_INCOMPLETE = 4'd6,
    ST_ZERO_LENGTH       = 4'd7,
    ST_LENGTH_EXCEEDS    = 4'd8,
    ST_HASH_ZERO         = 4'd9,
    ST_OVERSIZE          = 4'd10
  } tfph_status_t;

  // Decoded header state of one finished frame (byte count travels apart)
  typedef struct packed {
    logic        oversize;
    logic        side;
    logic [3:0]  ip_version;
    logic [3:0]  ip_header_words;
    logic [15:0] type_or_port;
    logic [15:0] length_field;
    logic [4:0]  tunnel_header_bytes;
    logic [31:0] hash;
  } tfph_frame_t;

  // h*33 + b, modulo 2^32
  function automatic logic [31:0] tfph_djb2(input logic [31:0] h, input logic [7:0] b);
    tfph_djb2 = (h << 5) + h + {24'd0, b};
  endfunction

endpackage

// ----- rtl/tfph_parser.sv -----
// ----------------------------------------------------------------------------
// tfph_parser
// Per-byte header decode and payload hash; snapshots the frame on last byte.
// ----------------------------------------------------------------------------
module tfph_parser #(
  parameter int MAX_FRAME_BYTES = tfph_pkg::MAX_FRAME_BYTES_DEFAULT,
  parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_side,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output tfph_pkg::tfph_frame_t snap,
  output logic [POS_W-1:0]      snap_pos
);
  import tfph_pkg::*;

  // frame state
  logic [POS_W-1:0] pos,  pos_next;
  logic [31:0]      hash, hash_next;
  logic [3:0]       ihw,  ihw_next;
  logic [3:0]       ver,  ver_next;
  logic [15:0]      top,  top_next;
  logic [15:0]      lf,   lf_next;
  logic [4:0]       thb,  thb_next;
  logic             side, side_next;
  logic [7:0]       sec,  sec_next;
  logic             ovs,  ovs_next;

  logic        step;
  logic [17:0] p;
  logic [5:0]  ihl4;
  logic [7:0]  u;
  logic [7:0]  s;
  logic        win;
  logic        special;
  logic [31:0] h_pre;

  assign in_ready = !snap_valid || snap_ready;
  assign step     = in_valid && in_ready;
  assign p        = 18'(pos);

  always_comb begin
    pos_next  = pos;
    hash_next = hash;
    ihw_next  = ihw;
    ver_next  = ver;
    top_next  = top;
    lf_next   = lf;
    thb_next  = thb;
    side_next = side;
    sec_next  = sec;
    ovs_next  = ovs;
    ihl4      = '0;
    u         = '0;
    s         = '0;
    win       = 1'b0;
    special   = 1'b0;
    h_pre     = hash;
    if (pos >= POS_W'(MAX_FRAME_BYTES)) begin
      ovs_next = 1'b1;
    end else begin
      if (pos == '0) begin
        side_next = in_side;
      end
      if (p == 18'd14) begin
        ver_next = in_byte[7:4];
        ihw_next = in_byte[3:0];
      end
      if (p == 18'd15) begin
        sec_next = in_byte;
      end
      ihl4 = {ihw_next, 2'b00};
      if (!side_next) begin
        // tunnel side: UDP at u, tunnel header at u+8
        u = 8'd14 + 8'(ihl4);
        if (p == 18'(u) + 18'd2) top_next[15:8] = in_byte;
        if (p == 18'(u) + 18'd3) top_next[7:0]  = in_byte;
        if (p == 18'(u) + 18'd8) begin
          thb_next = TUNNEL_HDR_BASE
                   + (in_byte[FLAG_ADD4_BIT] ? 5'd4 : 5'd0)
                   + (in_byte[FLAG_ADD2_BIT] ? 5'd2 : 5'd0)
                   + (in_byte[FLAG_ADD1_BIT] ? 5'd1 : 5'd0);
        end
        if (p == 18'(u) + 18'd10) lf_next[15:8] = in_byte;
        if (p == 18'(u) + 18'd11) lf_next[7:0]  = in_byte;
        s = u + 8'd8 + 8'(thb);
        if (p > 18'(u) + 18'd11 && p >= 18'(s) && p < 18'(s) + 18'(lf)) win = 1'b1;
      end else begin
        // plain side: ethertype at 12, IP total length at 16
        if (p == 18'd12) top_next[15:8] = in_byte;
        if (p == 18'd13) top_next[7:0]  = in_byte;
        if (p == 18'd16) lf_next[15:8]  = in_byte;
        if (p == 18'd17) lf_next[7:0]   = in_byte;
        // zero IHL with tiny total length: rebuild hash from the IP bytes
        special = (p == 18'd17) && (ihw_next == 4'd0) && (lf_next < 16'd3);
        if (special) begin
          h_pre = tfph_djb2(HASH_SEED, {ver_next, ihw_next});
          if (lf_next == 16'd2) h_pre = tfph_djb2(h_pre, sec_next);
        end
        if (p >= 18'd14 && p >= 18'd14 + 18'(ihl4)
            && (p < 18'd17 || p < 18'd14 + 18'(lf_next))) win = 1'b1;
      end
      hash_next = win ? tfph_djb2(h_pre, in_byte) : h_pre;
      pos_next  = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      hash <= HASH_SEED;
      ihw  <= '0;
      ver  <= '0;
      top  <= '0;
      lf   <= '0;
      thb  <= TUNNEL_HDR_BASE;
      side <= 1'b0;
      sec  <= '0;
      ovs  <= 1'b0;
    end else if (step && in_last) begin
      pos  <= '0;
      hash <= HASH_SEED;
      ihw  <= '0;
      ver  <= '0;
      top  <= '0;
      lf   <= '0;
      thb  <= TUNNEL_HDR_BASE;
      side <= 1'b0;
      sec  <= '0;
      ovs  <= 1'b0;
    end else if (step) begin
      pos  <= pos_next;
      hash <= hash_next;
      ihw  <= ihw_next;
      ver  <= ver_next;
      top  <= top_next;
      lf   <= lf_next;
      thb  <= thb_next;
      side <= side_next;
      sec  <= sec_next;
      ovs  <= ovs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (step && in_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      snap.oversize            <= ovs_next;
      snap.side                <= side_next;
      snap.ip_version          <= ver_next;
      snap.ip_header_words     <= ihw_next;
      snap.type_or_port        <= top_next;
      snap.length_field        <= lf_next;
      snap.tunnel_header_bytes <= thb_next;
      snap.hash                <= hash_next;
      snap_pos                 <= pos_next;
    end
  end

endmodule

// ----- rtl/tfph_verdict.sv -----
// ----------------------------------------------------------------------------
// tfph_verdict
// Ordered frame checks; yields status, payload length and hash.
// ----------------------------------------------------------------------------
module tfph_verdict #(
  parameter int POS_W = 15
) (
  input  tfph_pkg::tfph_frame_t  snap,
  input  logic [POS_W-1:0]       snap_pos,
  input  logic [15:0]            tunnel_udp_port,
  output tfph_pkg::tfph_status_t status,
  output logic [15:0]            payload_length,
  output logic [31:0]            payload_hash
);
  import tfph_pkg::*;

  logic [16:0]  c;
  logic [5:0]   ihl4;
  logic [6:0]   hdrs;
  logic [16:0]  diff;
  tfph_status_t st;
  logic [15:0]  plen;

  assign c    = 17'(snap_pos);
  assign ihl4 = {snap.ip_header_words, 2'b00};
  assign hdrs = 7'd22 + 7'(ihl4) + 7'(snap.tunnel_header_bytes);
  assign diff = {1'b0, snap.length_field} - 17'(ihl4);

  always_comb begin
    st   = ST_OK;
    plen = '0;
    if (snap.oversize) begin
      st = ST_OVERSIZE;
    end else if (!snap.side) begin
      priority if (c < 17'd50)                      st = ST_TOO_SHORT;
      else if (snap.ip_version != IP_VERSION_4)     st = ST_NOT_IPV4;
      else if (c < 17'd30 + 17'(ihl4))              st = ST_HDR_INCOMPLETE;
      else if (snap.type_or_port != tunnel_udp_port) st = ST_WRONG_PORT;
      else if (c < 17'(hdrs))                       st = ST_TUNNEL_INCOMPLETE;
      else begin
        plen = snap.length_field;
        if (plen == '0)                                  st = ST_ZERO_LENGTH;
        else if ({1'b0, plen} > c - 17'(hdrs))           st = ST_LENGTH_EXCEEDS;
      end
    end else begin
      priority if (c < 17'd34)                      st = ST_TOO_SHORT;
      else if (snap.type_or_port != ETHERTYPE_IPV4) st = ST_NOT_IP;
      else if (snap.ip_version != IP_VERSION_4)     st = ST_NOT_IPV4;
      else if (c < 17'd14 + 17'(ihl4))              st = ST_HDR_INCOMPLETE;
      else begin
        plen = diff[15:0];
        if (diff[16])                                     st = ST_LENGTH_EXCEEDS;
        else if (plen == '0)                              st = ST_ZERO_LENGTH;
        else if ({1'b0, plen} > c - 17'd14 - 17'(ihl4))   st = ST_LENGTH_EXCEEDS;
      end
    end
    if (st == ST_OK && snap.hash == '0) st = ST_HASH_ZERO;
  end

  assign status         = st;
  assign payload_length = plen;
  assign payload_hash   = (st == ST_OK) ? snap.hash : 32'd0;

endmodule

// ----- rtl/tunnel_frame_parse_and_hash_core.sv -----
// ----------------------------------------------------------------------------
// tunnel_frame_parse_and_hash_core
// Streams frame bytes, decodes tunnel or plain IP headers, hashes payload.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle unless the result side stalls;
//   one result per frame. Path: input register, then decode/hash snapshot,
//   then result register.
// Reset (rst, synchronous): empties all stages, clears the frame decode state
//   and loads the tunnel UDP port register with 2152. No clearing pass.
// ----------------------------------------------------------------------------
module tunnel_frame_parse_and_hash_core #(
  parameter int MAX_FRAME_BYTES = tfph_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // [0] side (0 tunnel, 1 plain)
  // per-frame result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [3:0] status, [19:4] payload_length,
                                      // [51:20] payload_hash, [55:52] zero
  // tunnel UDP port register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tfph_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0] tunnel_udp_port;

  // input register
  logic       in_valid;
  logic       in_side;
  logic [7:0] in_byte;
  logic       in_last;
  logic       parser_ready;

  // frame snapshot between decode and checks
  logic             snap_valid;
  logic             snap_ready;
  tfph_frame_t      snap;
  logic [POS_W-1:0] snap_pos;

  // checks
  tfph_status_t v_status;
  logic [15:0]  v_length;
  logic [31:0]  v_hash;

  // result register
  logic         out_valid;
  tfph_status_t out_status;
  logic [15:0]  out_length;
  logic [31:0]  out_hash;
  logic         out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tunnel_udp_port <= TUNNEL_PORT_RESET;
    end else if (cfg_wr_en) begin
      tunnel_udp_port <= cfg_wr_data;
    end
  end

  // Input stage: takes a byte whenever it is empty or draining this cycle.
  assign s_axis_tready = !in_valid || parser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_side <= s_axis_tuser;
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Decode + DJB2 step per byte; frame state resets after each last byte.
  tfph_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .POS_W           (POS_W)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (parser_ready),
    .in_side    (in_side),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_pos   (snap_pos)
  );

  // Ordered status checks on the finished frame.
  tfph_verdict #(
    .POS_W (POS_W)
  ) u_verdict (
    .snap            (snap),
    .snap_pos        (snap_pos),
    .tunnel_udp_port (tunnel_udp_port),
    .status          (v_status),
    .payload_length  (v_length),
    .payload_hash    (v_hash)
  );

  // Result register: takes the snapshot when empty or as the previous result leaves.
  assign out_ready  = !out_valid || m_axis_tready;
  assign snap_ready = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && out_ready) begin
      out_status <= v_status;
      out_length <= v_length;
      out_hash   <= v_hash;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_hash, out_length, out_status};

  // hash is reported only for a good frame
  a_hash_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_hash == 32'd0)
    else $error("hash reported on a failed frame");

  // early failures carry no length
  a_len_zero_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_TOO_SHORT || out_status == ST_NOT_IP ||
                  out_status == ST_NOT_IPV4 || out_status == ST_HDR_INCOMPLETE ||
                  out_status == ST_WRONG_PORT || out_status == ST_TUNNEL_INCOMPLETE ||
                  out_status == ST_OVERSIZE) |-> out_length == 16'd0)
    else $error("length reported on an early failure");

  // a stalled snapshot is neither lost nor overwritten
  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap) && $stable(snap_pos))
    else $error("frame snapshot changed under stall");

  // every last byte taken by the decoder yields a snapshot
  a_last_snaps: assert property (@(posedge clk) disable iff (rst)
    in_valid && parser_ready && in_last |=> snap_valid)
    else $error("last byte produced no frame snapshot");

endmodule

// ----- sim/tb_tunnel_frame_parse_and_hash_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tunnel_frame_parse_and_hash_core
// Streams tunnel and plain frames byte by byte into the core. A local decoder
// predicts status, payload length and payload hash for every frame, and each
// result is checked against it. Covers directed header cases, the frame size
// limit, the tunnel UDP port register and random traffic with random flow
// control on both sides.
// ----------------------------------------------------------------------------
module tb_tunnel_frame_parse_and_hash_core;
  import tfph_pkg::*;

  localparam int      CLK_PERIOD    = 20;
  localparam int      DRAIN_CYCLES  = 10;
  localparam longint  TIMEOUT_NS    = 64'd5_000_000 * CLK_PERIOD;
  localparam int      FRAME_LIMIT   = MAX_FRAME_BYTES_DEFAULT;

  // frame layout
  localparam int ETH_HDR_BYTES    = 14;
  localparam int UDP_HDR_BYTES    = 8;
  localparam int MIN_TUNNEL_FRAME = 50;
  localparam int MIN_PLAIN_FRAME  = 34;
  localparam bit SIDE_TUNNEL      = 1'b0;
  localparam bit SIDE_PLAIN       = 1'b1;

  typedef struct packed {
    tfph_status_t status;
    logic [15:0]  payload_length;
    logic [31:0]  payload_hash;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tlast;   // last_byte
  logic        s_axis_tuser;   // [0] side
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [55:0] m_axis_tdata;   // [3:0] status, [19:4] payload_length,
                               // [51:20] payload_hash
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  tunnel_frame_parse_and_hash_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame decoder: mirrors the core's per-frame header state
  // --------------------------------------------------------------------------
  logic [15:0] tunnel_port;
  int unsigned byte_count;
  logic [31:0] payload_hash_acc;
  logic [3:0]  ihl_words;
  logic [3:0]  ip_ver;
  logic [15:0] type_port;      // ethertype (plain) or UDP dest port (tunnel)
  logic [15:0] len_field;
  logic [4:0]  gtp_hdr_len;
  logic        cur_side;
  logic [7:0]  ip_byte2;
  logic        too_big;

  frame_result_t pending_frame_results[$];
  logic [7:0]    frame_bytes[$];
  int            error_count = 0;
  int            burst_left  = 0;

  function automatic logic [31:0] djb2_fold(logic [31:0] h, logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

  function automatic void restart_frame();
    byte_count       = 0;
    payload_hash_acc = HASH_SEED;
    ihl_words        = '0;
    ip_ver           = '0;
    type_port        = '0;
    len_field        = '0;
    gtp_hdr_len      = TUNNEL_HDR_BASE;
    cur_side         = 1'b0;
    ip_byte2         = '0;
    too_big          = 1'b0;
  endfunction

  function automatic void decode_byte(int unsigned p, logic [7:0] b);
    int unsigned ihl4;
    int unsigned u;
    int unsigned s;
    bit          hashed;
    hashed = 1'b0;
    if (p == ETH_HDR_BYTES) begin
      ip_ver    = b[7:4];
      ihl_words = b[3:0];
    end
    if (p == ETH_HDR_BYTES + 1) ip_byte2 = b;
    ihl4 = ihl_words * 4;
    if (cur_side == SIDE_TUNNEL) begin
      // UDP starts right after IHL words, even when they overlap the IP header
      u = ETH_HDR_BYTES + ihl4;
      if (p >= 15 && p == u + 2) type_port[15:8] = b;
      if (p >= 15 && p == u + 3) type_port[7:0] = b;
      if (p >= 15 && p == u + 8)
        gtp_hdr_len = TUNNEL_HDR_BASE + (b[FLAG_ADD4_BIT] ? 5'd4 : 5'd0)
                    + (b[FLAG_ADD2_BIT] ? 5'd2 : 5'd0) + (b[FLAG_ADD1_BIT] ? 5'd1 : 5'd0);
      if (p >= 15 && p == u + 10) len_field[15:8] = b;
      if (p >= 15 && p == u + 11) len_field[7:0] = b;
      if (p >= 15 && p > u + 11) begin
        s = u + UDP_HDR_BYTES + gtp_hdr_len;
        if (p >= s && p < s + len_field) hashed = 1'b1;
      end
    end else begin
      if (p == 12) type_port[15:8] = b;
      if (p == 13) type_port[7:0] = b;
      if (p == 16) len_field[15:8] = b;
      if (p == 17) len_field[7:0] = b;
      // zero IHL: payload began at the version byte, rehash once length is known
      if (p == 17 && ihl_words == 0 && len_field < 3) begin
        payload_hash_acc = djb2_fold(HASH_SEED, {ip_ver, ihl_words});
        if (len_field == 2) payload_hash_acc = djb2_fold(payload_hash_acc, ip_byte2);
      end
      if (p >= ETH_HDR_BYTES && p >= ETH_HDR_BYTES + ihl4 &&
          (p < 17 || p < ETH_HDR_BYTES + len_field))
        hashed = 1'b1;
    end
    if (hashed) payload_hash_acc = djb2_fold(payload_hash_acc, b);
  endfunction

  function automatic frame_result_t close_frame();
    frame_result_t r;
    int unsigned   c;
    int unsigned   ihl4;
    int unsigned   hdrs;
    c    = byte_count;
    ihl4 = ihl_words * 4;
    r.status         = ST_OK;
    r.payload_length = '0;
    r.payload_hash   = '0;
    if (too_big) begin
      r.status = ST_OVERSIZE;
    end else if (cur_side == SIDE_TUNNEL) begin
      hdrs = ETH_HDR_BYTES + UDP_HDR_BYTES + ihl4 + gtp_hdr_len;
      if (c < MIN_TUNNEL_FRAME) r.status = ST_TOO_SHORT;
      else if (ip_ver != IP_VERSION_4) r.status = ST_NOT_IPV4;
      else if (c < ETH_HDR_BYTES + 2 * UDP_HDR_BYTES + ihl4) r.status = ST_HDR_INCOMPLETE;
      else if (type_port != tunnel_port) r.status = ST_WRONG_PORT;
      else if (c < hdrs) r.status = ST_TUNNEL_INCOMPLETE;
      else begin
        r.payload_length = len_field;
        if (len_field == 0) r.status = ST_ZERO_LENGTH;
        else if (len_field > c - hdrs) r.status = ST_LENGTH_EXCEEDS;
      end
    end else begin
      if (c < MIN_PLAIN_FRAME) r.status = ST_TOO_SHORT;
      else if (type_port != ETHERTYPE_IPV4) r.status = ST_NOT_IP;
      else if (ip_ver != IP_VERSION_4) r.status = ST_NOT_IPV4;
      else if (c < ETH_HDR_BYTES + ihl4) r.status = ST_HDR_INCOMPLETE;
      else begin
        // negative lengths wrap to 16 bits
        r.payload_length = len_field - 16'(ihl4);
        if (len_field < ihl4) r.status = ST_LENGTH_EXCEEDS;
        else if (r.payload_length == 0) r.status = ST_ZERO_LENGTH;
        else if (r.payload_length > c - ETH_HDR_BYTES - ihl4) r.status = ST_LENGTH_EXCEEDS;
      end
    end
    if (r.status == ST_OK) begin
      r.payload_hash = payload_hash_acc;
      if (payload_hash_acc == 0) r.status = ST_HASH_ZERO;
    end
    return r;
  endfunction

  function automatic void predict_frame_byte(logic side, logic [7:0] b, logic last);
    if (byte_count >= FRAME_LIMIT) begin
      too_big = 1'b1;  // bytes past the limit are not decoded
    end else begin
      if (byte_count == 0) cur_side = side;
      decode_byte(byte_count, b);
      byte_count++;
    end
    if (last) begin
      pending_frame_results.push_back(close_frame());
      restart_frame();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Frame builders: fill frame_bytes with random bytes, then place the fields
  // --------------------------------------------------------------------------
  function automatic void trim_frame(int keep);
    if (keep > 0)
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endfunction

  function automatic void build_tunnel_frame(int ihl, logic [3:0] ver, logic [15:0] udp_port,
                                             logic [7:0] flags, logic [15:0] len,
                                             int pay, int tail, int keep);
    int u;
    int hdr;
    hdr = 8 + (flags[FLAG_ADD4_BIT] ? 4 : 0) + (flags[FLAG_ADD2_BIT] ? 2 : 0)
        + (flags[FLAG_ADD1_BIT] ? 1 : 0);
    u = ETH_HDR_BYTES + ihl * 4;
    frame_bytes = {};
    repeat (u + UDP_HDR_BYTES + hdr + pay + tail)
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes[ETH_HDR_BYTES] = {ver, 4'(ihl)};
    frame_bytes[u + 2]  = udp_port[15:8];
    frame_bytes[u + 3]  = udp_port[7:0];
    frame_bytes[u + 8]  = flags;
    frame_bytes[u + 10] = len[15:8];
    frame_bytes[u + 11] = len[7:0];
    trim_frame(keep);
  endfunction

  function automatic void build_plain_frame(int ihl, logic [3:0] ver, logic [15:0] etype,
                                            logic [15:0] total_len, int pay, int tail,
                                            int keep);
    int n;
    n = ETH_HDR_BYTES + ihl * 4 + pay + tail;
    if (n < 18) n = 18;
    frame_bytes = {};
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes[12] = etype[15:8];
    frame_bytes[13] = etype[7:0];
    frame_bytes[ETH_HDR_BYTES] = {ver, 4'(ihl)};
    frame_bytes[16] = total_len[15:8];
    frame_bytes[17] = total_len[7:0];
    trim_frame(keep);
  endfunction

  // --------------------------------------------------------------------------
  // Stream driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(logic side, logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      // now and then a long gap-free stretch
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= side;
    do @(posedge clk); while (!s_axis_tready);
    predict_frame_byte(side, b, last);
  endtask

  // jitter: side flips at random after the first byte, which the core ignores
  task automatic send_frame(logic side, bit jitter);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte((i == 0 || !jitter) ? side : 1'($urandom_range(0, 1)), frame_bytes[i],
                i == frame_bytes.size() - 1);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tunnel_port(logic [15:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tunnel_port = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side: own stall pattern, and the check of every result
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'b1011_0010_1110_0111;
  int unsigned ready_tick    = 0;

  always @(negedge clk) begin
    ready_tick++;
    case ((ready_tick / 300) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= stall_pattern[ready_tick % 16];
      2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (ready_tick % 7) == 0;
    endcase
  end

  always @(posedge clk) begin : check_result
    frame_result_t want;
    frame_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status         = tfph_status_t'(m_axis_tdata[3:0]);
      got.payload_length = m_axis_tdata[19:4];
      got.payload_hash   = m_axis_tdata[51:20];
      if (pending_frame_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0d len %0d hash %h",
                 $time, got.status, got.payload_length, got.payload_hash);
      end else begin
        want = pending_frame_results.pop_front();
        if (got.status != want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got.status);
        end
        if (got.payload_length != want.payload_length) begin
          error_count++;
          $display("%0t: payload_length mismatch, expected %0d, actual %0d",
                   $time, want.payload_length, got.payload_length);
        end
        if (got.payload_hash != want.payload_hash) begin
          error_count++;
          $display("%0t: payload_hash mismatch, expected %h, actual %h",
                   $time, want.payload_hash, got.payload_hash);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_tunnel_directed();
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd10, 10, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    // all three extension flags, trailing bytes after the payload
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'hE0, 16'd5, 5, 3, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h80, 16'd1, 1, 20, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd10, 10, 0, 49);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, 4'd6, TUNNEL_PORT_RESET, 8'h00, 16'd10, 10, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(15, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd10, 10, 0, 80);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET + 16'd1, 8'h00, 16'd10, 10, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    // cut inside the extended tunnel header
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'hE0, 16'd10, 10, 0, 56);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h40, 16'd0, 3, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h20, 16'd20, 5, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'hFF, 16'hFFFF, 3, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    // zero IHL: UDP overlaps the IP header
    build_tunnel_frame(0, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd4, 4, 20, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    // side flips mid-frame
    build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd12, 12, 0, 0);
    send_frame(SIDE_TUNNEL, 1'b1);
    frame_bytes = {};
    repeat (60) frame_bytes.push_back(8'hFF);
    send_frame(SIDE_TUNNEL, 1'b0);
    frame_bytes = {8'h00};
    send_frame(SIDE_TUNNEL, 1'b0);
  endtask

  task automatic test_plain_directed();
    longint unsigned residue;
    longint unsigned weight;
    logic [7:0]      digit[7];
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd40, 20, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd40, 20, 0, 33);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, 16'h86DD, 16'd40, 20, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, 4'd6, ETHERTYPE_IPV4, 16'd40, 20, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(15, IP_VERSION_4, ETHERTYPE_IPV4, 16'd80, 20, 0, 50);
    send_frame(SIDE_PLAIN, 1'b0);
    // total length below the IP header: wraps and reports length exceeded
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd10, 20, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd20, 5, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd70, 10, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    // zero IHL: payload starts at the version byte; short total lengths, then a longer one
    build_plain_frame(0, IP_VERSION_4, ETHERTYPE_IPV4, 16'd0, 0, 30, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(0, IP_VERSION_4, ETHERTYPE_IPV4, 16'd1, 0, 30, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(0, IP_VERSION_4, ETHERTYPE_IPV4, 16'd2, 0, 30, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(0, IP_VERSION_4, ETHERTYPE_IPV4, 16'd40, 40, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd30, 10, 0, 0);
    send_frame(SIDE_PLAIN, 1'b1);
    // payload chosen as base-33 digits so that the hash wraps to zero
    weight = 1;
    repeat (7) weight = weight * 33;
    residue = (64'h1_0000_0000 - ((64'(HASH_SEED) * weight) & 64'hFFFF_FFFF))
              & 64'hFFFF_FFFF;
    for (int i = 6; i >= 0; i--) begin
      digit[i] = 8'(residue % 33);
      residue  = residue / 33;
    end
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd27, 7, 0, 0);
    for (int i = 0; i < 7; i++) frame_bytes[MIN_PLAIN_FRAME + i] = digit[i];
    send_frame(SIDE_PLAIN, 1'b0);
    frame_bytes = {8'h45};
    send_frame(SIDE_PLAIN, 1'b0);
  endtask

  task automatic test_frame_size_limit();
    // exactly at the limit decodes normally; one byte more is oversize; then a tunnel frame
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'(20 + FRAME_LIMIT - 34),
                      FRAME_LIMIT - 34, 0, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_plain_frame(5, IP_VERSION_4, ETHERTYPE_IPV4, 16'd100, 80, FRAME_LIMIT - 113, 0);
    send_frame(SIDE_PLAIN, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, tunnel_port, 8'h00, 16'd30, 30, FRAME_LIMIT - 70, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
    build_tunnel_frame(5, IP_VERSION_4, tunnel_port, 8'h00, 16'd30, 30, 10, 0);
    send_frame(SIDE_TUNNEL, 1'b0);
  endtask

  task automatic test_tunnel_port_register();
    logic [15:0] settings[3];
    settings[0] = 16'h0000;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(0, 65535));
    foreach (settings[i]) begin
      wait_for_results();
      write_tunnel_port(settings[i]);
      build_tunnel_frame(5, IP_VERSION_4, settings[i], 8'h00, 16'd8, 8, 0, 0);
      send_frame(SIDE_TUNNEL, 1'b0);
      build_tunnel_frame(5, IP_VERSION_4, settings[i] ^ 16'h0001, 8'h00, 16'd8, 8, 0, 0);
      send_frame(SIDE_TUNNEL, 1'b0);
      build_tunnel_frame(5, IP_VERSION_4, TUNNEL_PORT_RESET, 8'h00, 16'd8, 8, 0, 0);
      send_frame(SIDE_TUNNEL, 1'b0);
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int          phase_bytes;
    int          phase_frames;
    int          kind;
    int          fault;
    int          ihl;
    int          u;
    int          pay;
    int          tail;
    int          keep;
    logic        side;
    logic [3:0]  ver;
    logic [7:0]  flags;
    logic [15:0] len;
    logic [15:0] tag;
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_results();
      write_tunnel_port(phase == 3 ? TUNNEL_PORT_RESET : 16'($urandom_range(0, 65535)));
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < 440 || phase_frames < 12) begin
        kind  = $urandom_range(0, 99);
        ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        u     = ETH_HDR_BYTES + ihl * 4;
        pay   = $urandom_range(1, 40);
        tail  = $urandom_range(0, 4);
        flags = 8'($urandom_range(0, 255));
        if (kind < 40) begin
          side = SIDE_TUNNEL;
          len  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, pay + 5)) : 16'(pay);
          if (u + 16 + pay + tail < MIN_TUNNEL_FRAME)
            tail = MIN_TUNNEL_FRAME - u - 16 - pay + $urandom_range(0, 4);
          build_tunnel_frame(ihl, IP_VERSION_4, tunnel_port, flags, len, pay, tail, 0);
        end else if (kind < 75) begin
          side = SIDE_PLAIN;
          if (u + pay < MIN_PLAIN_FRAME) pay = MIN_PLAIN_FRAME - u + $urandom_range(0, 8);
          len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, ihl * 4 + pay + 8))
                                            : 16'(ihl * 4 + pay);
          build_plain_frame(ihl, IP_VERSION_4, ETHERTYPE_IPV4, len, pay, tail, 0);
        end else if (kind < 90) begin
          // well-formed frame with one field broken or the capture cut short
          side  = 1'($urandom_range(0, 1));
          fault = $urandom_range(0, 2);
          ver   = (fault == 0) ? 4'($urandom_range(0, 15)) : IP_VERSION_4;
          keep  = (fault == 2) ? $urandom_range(1, 70) : 0;
          tag   = 16'($urandom_range(0, 65535));
          if (side == SIDE_TUNNEL)
            build_tunnel_frame(ihl, ver, (fault == 1) ? tag : tunnel_port, flags,
                               16'(pay), pay, tail + 20, keep);
          else
            build_plain_frame(ihl, ver, (fault == 1) ? tag : ETHERTYPE_IPV4,
                              16'(ihl * 4 + pay), pay, tail + 20, keep);
        end else begin
          side = 1'($urandom_range(0, 1));
          frame_bytes = {};
          repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(side, $urandom_range(0, 9) == 0);
        phase_bytes += frame_bytes.size();
        phase_frames++;
      end
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    tunnel_port = TUNNEL_PORT_RESET;
    restart_frame();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_tunnel_directed();
    test_plain_directed();
    test_frame_size_limit();
    test_tunnel_port_register();
    test_random_traffic();

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
